[hdl/rse_pkg.sv]
// shared types and constants for the rpn stack evaluator
package rse_pkg;

    // command codes
    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_OP     = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    // operator characters
    localparam logic [7:0] OP_ADD = 8'h2B;
    localparam logic [7:0] OP_SUB = 8'h2D;
    localparam logic [7:0] OP_MUL = 8'h2A;
    localparam logic [7:0] OP_DIV = 8'h2F;

    // status codes
    localparam logic [2:0] STATUS_OK    = 3'd0;
    localparam logic [2:0] STATUS_DIV0  = 3'd1;
    localparam logic [2:0] STATUS_BADOP = 3'd2;
    localparam logic [2:0] STATUS_UNDER = 3'd3;
    localparam logic [2:0] STATUS_OVER  = 3'd4;
    localparam logic [2:0] STATUS_SAT   = 3'd5;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    localparam int ITER_W = 5;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] token_value;
        logic [7:0]         op_char;
    } rse_in_t;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic [4:0]         stack_depth;
        logic [2:0]         status;
    } rse_out_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic        start;
        alu_op_t     op;
        logic [31:0] a;
        logic [31:0] b;
    } rse_arith_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
        logic        sat;
    } rse_arith_resp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ARITH,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        AS_IDLE,
        AS_SETUP,
        AS_CHECK,
        AS_ITER,
        AS_FINAL
    } arith_state_t;

endpackage

[hdl/rse_stack_mem.sv]
// operand stack storage: one write port, one registered read port
module rse_stack_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

[hdl/rse_arith.sv]
// shared fixed-point arithmetic unit: add/sub, shift-add multiply, shift-subtract divide
module rse_arith #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  rse_pkg::rse_arith_req_t  req,
    output rse_pkg::rse_arith_resp_t resp
);

    rse_pkg::arith_state_t as_state_reg, as_state_next;
    rse_pkg::alu_op_t      op_reg, op_next;
    logic [31:0]           a_reg, a_next;
    logic [31:0]           b_reg, b_next;
    logic                  neg_reg, neg_next;
    logic [31:0]           hi_reg, hi_next;
    logic [31:0]           lo_reg, lo_next;
    logic [31:0]           opd_reg, opd_next;
    logic [rse_pkg::ITER_W-1:0] cnt_reg, cnt_next;
    logic [31:0]           res_reg, res_next;
    logic                  sat_reg, sat_next;
    logic                  done_reg, done_next;

    // the adder shared by every operation
    logic [32:0] add_x;
    logic [32:0] add_y;
    logic        add_sub;
    logic [33:0] add_sum;

    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [63:0] dvd;
    logic [63:0] m_full;
    logic        m_over;

    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        unique case (as_state_reg)
            rse_pkg::AS_SETUP:
            begin
                add_x   = {a_reg[31], a_reg};
                add_y   = {b_reg[31], b_reg};
                add_sub = (op_reg == rse_pkg::ALU_SUB);
            end
            rse_pkg::AS_CHECK:
            begin
                add_x   = {1'b0, hi_reg};
                add_y   = {1'b0, opd_reg};
                add_sub = 1'b1;
            end
            rse_pkg::AS_ITER:
            begin
                if (op_reg == rse_pkg::ALU_MUL)
                begin
                    add_x = {1'b0, hi_reg};
                    add_y = lo_reg[0] ? {1'b0, opd_reg} : 33'd0;
                end
                else
                begin
                    add_x   = {hi_reg, lo_reg[31]};
                    add_y   = {1'b0, opd_reg};
                    add_sub = 1'b1;
                end
            end
            default:
            begin
                add_x   = '0;
                add_y   = '0;
                add_sub = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_x} + {1'b0, add_sub ? ~add_y : add_y} + {33'd0, add_sub};

    assign mag_a = a_reg[31] ? (32'd0 - a_reg) : a_reg;
    assign mag_b = b_reg[31] ? (32'd0 - b_reg) : b_reg;
    assign dvd   = {32'd0, mag_a} << FRAC_BITS;

    always_comb
    begin
        as_state_next = as_state_reg;
        op_next       = op_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        neg_next      = neg_reg;
        hi_next       = hi_reg;
        lo_next       = lo_reg;
        opd_next      = opd_reg;
        cnt_next      = cnt_reg;
        res_next      = res_reg;
        sat_next      = sat_reg;
        done_next     = 1'b0;
        m_full        = (op_reg == rse_pkg::ALU_MUL) ? ({hi_reg, lo_reg} >> FRAC_BITS)
                                                      : {32'd0, lo_reg};
        m_over        = 1'b0;

        unique case (as_state_reg)
            rse_pkg::AS_IDLE:
            begin
                if (req.start)
                begin
                    op_next       = req.op;
                    a_next        = req.a;
                    b_next        = req.b;
                    as_state_next = rse_pkg::AS_SETUP;
                end
            end
            rse_pkg::AS_SETUP:
            begin
                neg_next = a_reg[31] ^ b_reg[31];
                cnt_next = '0;
                unique case (op_reg)
                    rse_pkg::ALU_ADD, rse_pkg::ALU_SUB:
                    begin
                        // 33-bit signed result, out of range when the top two bits differ
                        sat_next      = add_sum[32] ^ add_sum[31];
                        res_next      = (add_sum[32] ^ add_sum[31])
                                        ? (add_sum[32] ? rse_pkg::SAT_MIN : rse_pkg::SAT_MAX)
                                        : add_sum[31:0];
                        done_next     = 1'b1;
                        as_state_next = rse_pkg::AS_IDLE;
                    end
                    rse_pkg::ALU_MUL:
                    begin
                        hi_next       = '0;
                        lo_next       = mag_b;
                        opd_next      = mag_a;
                        as_state_next = rse_pkg::AS_ITER;
                    end
                    rse_pkg::ALU_DIV:
                    begin
                        hi_next       = dvd[63:32];
                        lo_next       = dvd[31:0];
                        opd_next      = mag_b;
                        as_state_next = rse_pkg::AS_CHECK;
                    end
                    default:
                    begin
                        as_state_next = rse_pkg::AS_IDLE;
                    end
                endcase
            end
            rse_pkg::AS_CHECK:
            begin
                // quotient of 2^32 or more clamps either way
                if (add_sum[33])
                begin
                    sat_next      = 1'b1;
                    res_next      = neg_reg ? rse_pkg::SAT_MIN : rse_pkg::SAT_MAX;
                    done_next     = 1'b1;
                    as_state_next = rse_pkg::AS_IDLE;
                end
                else
                begin
                    as_state_next = rse_pkg::AS_ITER;
                end
            end
            rse_pkg::AS_ITER:
            begin
                if (op_reg == rse_pkg::ALU_MUL)
                begin
                    hi_next = add_sum[32:1];
                    lo_next = {add_sum[0], lo_reg[31:1]};
                end
                else
                begin
                    hi_next = add_sum[33] ? add_sum[31:0] : add_x[31:0];
                    lo_next = {lo_reg[30:0], add_sum[33]};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    as_state_next = rse_pkg::AS_FINAL;
                end
            end
            rse_pkg::AS_FINAL:
            begin
                if (neg_reg)
                begin
                    m_over   = (m_full[63:32] != 32'd0) || (m_full[31] && (m_full[30:0] != 31'd0));
                    res_next = m_over ? rse_pkg::SAT_MIN : (32'd0 - m_full[31:0]);
                end
                else
                begin
                    m_over   = (m_full[63:31] != 33'd0);
                    res_next = m_over ? rse_pkg::SAT_MAX : m_full[31:0];
                end
                sat_next      = m_over;
                done_next     = 1'b1;
                as_state_next = rse_pkg::AS_IDLE;
            end
            default:
            begin
                as_state_next = rse_pkg::AS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            as_state_reg <= rse_pkg::AS_IDLE;
            done_reg     <= 1'b0;
        end
        else
        begin
            as_state_reg <= as_state_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        neg_reg <= neg_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        opd_reg <= opd_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
        sat_reg <= sat_next;
    end

    assign resp.done   = done_reg;
    assign resp.result = res_reg;
    assign resp.sat    = sat_reg;

endmodule

[hdl/rpn_stack_evaluator.sv]
// top level of the rpn stack evaluator: sequencer, stack pointer and output register
//
// usage: tokens come in on the item channel (valid/ready), one result per token
// leaves on the result channel (valid/ready). a push stacks token_value, an
// operator pops right then left and pushes the result, finish pops the answer
// and empties the stack. values are signed fixed point with FRAC_BITS fraction bits.
// timing: one token at a time; item_ready is high only while the sequencer is idle.
// push, finish, the unused command, divide by zero and a bad operator go from EXEC
// straight to DONE; +, -, * and / wait in ARITH for the shared arithmetic unit,
// whose * and / run a 32-step shift-add / shift-subtract loop (a / whose quotient
// clamps at once skips the loop).
// item_ready rises in the cycle after a result moves to the output register.
// a stalled receiver holds one finished result in the output register; the block
// takes and works the next token, then waits until the output register frees up.
// reset empties the stack and clears both channels; stack storage is not cleared.
module rpn_stack_evaluator #(
    parameter int STACK_DEPTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  rse_pkg::rse_in_t item,
    output logic             result_valid,
    input  logic             result_ready,
    output rse_pkg::rse_out_t result
);

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int AW   = $clog2(STACK_DEPTH);
    localparam logic [31:0] NEG_ONE = 32'd0 - (32'd1 << FRAC_BITS);
    localparam logic [31:0] NEG_TWO = 32'd0 - (32'd2 << FRAC_BITS);

    rse_pkg::state_t   state_reg, state_next;
    rse_pkg::rse_in_t  in_reg;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [31:0]       top_reg, top_next;
    rse_pkg::rse_out_t pend_reg, pend_next;
    rse_pkg::rse_out_t out_reg;
    logic              out_valid_reg;

    rse_pkg::rse_arith_req_t  arith_req;
    rse_pkg::rse_arith_resp_t arith_resp;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [AW-1:0] lower_addr;
    logic [31:0]   rd_data;

    logic            sp_ge1;
    logic            sp_ge2;
    logic            sp_full;
    logic [31:0]     right_opd;
    logic [31:0]     left_opd;
    logic [SP_W-1:0] sp_after_op;
    logic            op_ok;
    rse_pkg::alu_op_t alu_op;

    logic        do_commit;
    logic [31:0] commit_val;
    logic [2:0]  commit_st;
    logic        pend_load;
    logic [31:0] pend_val;
    logic [2:0]  pend_st;
    logic [31:0] sp_next_w;
    logic        out_free;

    assign sp_ge1      = (sp_reg != '0);
    assign sp_ge2      = (sp_reg >= SP_W'(2));
    assign sp_full     = (sp_reg >= SP_W'(STACK_DEPTH));
    assign lower_addr  = sp_ge2 ? AW'(sp_reg - SP_W'(2)) : '0;
    assign right_opd   = sp_ge1 ? top_reg : 32'd0;
    assign left_opd    = sp_ge2 ? rd_data : 32'd0;
    assign sp_after_op = sp_ge2 ? (sp_reg - 1'b1) : SP_W'(1);
    assign sp_next_w   = 32'(sp_next);
    assign out_free    = !out_valid_reg || result_ready;

    always_comb
    begin
        op_ok  = 1'b1;
        alu_op = rse_pkg::ALU_ADD;
        unique case (in_reg.op_char)
            rse_pkg::OP_ADD: alu_op = rse_pkg::ALU_ADD;
            rse_pkg::OP_SUB: alu_op = rse_pkg::ALU_SUB;
            rse_pkg::OP_MUL: alu_op = rse_pkg::ALU_MUL;
            rse_pkg::OP_DIV: alu_op = rse_pkg::ALU_DIV;
            default:         op_ok  = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        sp_next     = sp_reg;
        top_next    = top_reg;
        pend_next   = pend_reg;
        wr_en       = 1'b0;
        wr_addr     = lower_addr;
        wr_data     = in_reg.token_value;
        arith_req.start = 1'b0;
        arith_req.op    = alu_op;
        arith_req.a     = left_opd;
        arith_req.b     = right_opd;
        do_commit   = 1'b0;
        commit_val  = arith_resp.result;
        commit_st   = rse_pkg::STATUS_OK;
        pend_load   = 1'b0;
        pend_val    = top_reg;
        pend_st     = rse_pkg::STATUS_OK;

        unique case (state_reg)
            rse_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = rse_pkg::ST_EXEC;
                end
            end
            rse_pkg::ST_EXEC:
            begin
                state_next = rse_pkg::ST_DONE;
                unique case (in_reg.cmd)
                    rse_pkg::CMD_PUSH:
                    begin
                        pend_load = 1'b1;
                        if (!sp_full)
                        begin
                            wr_en    = 1'b1;
                            wr_addr  = sp_reg[AW-1:0];
                            sp_next  = sp_reg + 1'b1;
                            top_next = in_reg.token_value;
                            pend_val = in_reg.token_value;
                        end
                        else
                        begin
                            pend_st = rse_pkg::STATUS_OVER;
                        end
                    end
                    rse_pkg::CMD_OP:
                    begin
                        if (!op_ok)
                        begin
                            do_commit  = 1'b1;
                            commit_val = NEG_TWO;
                            commit_st  = rse_pkg::STATUS_BADOP;
                        end
                        else if ((alu_op == rse_pkg::ALU_DIV) && (right_opd == 32'd0))
                        begin
                            do_commit  = 1'b1;
                            commit_val = NEG_ONE;
                            commit_st  = rse_pkg::STATUS_DIV0;
                        end
                        else
                        begin
                            arith_req.start = 1'b1;
                            state_next      = rse_pkg::ST_ARITH;
                        end
                    end
                    rse_pkg::CMD_FINISH:
                    begin
                        pend_load = 1'b1;
                        pend_val  = right_opd;
                        pend_st   = sp_ge1 ? rse_pkg::STATUS_OK : rse_pkg::STATUS_UNDER;
                        sp_next   = '0;
                    end
                    default:
                    begin
                        pend_load = 1'b1;
                        pend_val  = right_opd;
                    end
                endcase
            end
            rse_pkg::ST_ARITH:
            begin
                if (arith_resp.done)
                begin
                    do_commit  = 1'b1;
                    commit_val = arith_resp.result;
                    commit_st  = arith_resp.sat ? rse_pkg::STATUS_SAT : rse_pkg::STATUS_OK;
                    state_next = rse_pkg::ST_DONE;
                end
            end
            rse_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = rse_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rse_pkg::ST_IDLE;
            end
        endcase

        // operator result replaces the popped operands; a missing operand wins the status
        if (do_commit)
        begin
            wr_en     = 1'b1;
            wr_addr   = lower_addr;
            wr_data   = commit_val;
            sp_next   = sp_after_op;
            top_next  = commit_val;
            pend_load = 1'b1;
            pend_val  = commit_val;
            pend_st   = sp_ge2 ? commit_st : rse_pkg::STATUS_UNDER;
        end

        if (pend_load)
        begin
            pend_next.top_value   = pend_val;
            pend_next.stack_depth = sp_next_w[4:0];
            pend_next.status      = pend_st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rse_pkg::ST_IDLE;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            if ((state_reg == rse_pkg::ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg  <= top_next;
        pend_reg <= pend_next;
        if (item_valid && item_ready)
        begin
            in_reg <= item;
        end
        if ((state_reg == rse_pkg::ST_DONE) && out_free)
        begin
            out_reg <= pend_reg;
        end
    end

    rse_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (lower_addr),
        .rd_data (rd_data)
    );

    rse_arith #(
        .FRAC_BITS (FRAC_BITS)
    ) u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (arith_req),
        .resp  (arith_resp)
    );

    assign item_ready   = (state_reg == rse_pkg::ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
